// ===== design/gregorian_to_lunar_date_assert.svh =====
`ifndef GREGORIAN_TO_LUNAR_DATE_ASSERT_SVH
`define GREGORIAN_TO_LUNAR_DATE_ASSERT_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define G2L_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define G2L_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== design/g2l_pkg.sv =====
`default_nettype none
package g2l_pkg;

  localparam int unsigned RomWords = 200;
  localparam int unsigned BaseYear = 1900;
  localparam int unsigned TableYearsDef = 200;

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } g2l_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        leap_month_flag;
  } g2l_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_GMON, ST_LYEAR, ST_LMON, ST_DONE
  } g2l_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic check;
    logic gmon_step;
    logic lyear_step;
    logic lmon_step;
    logic fail;
  } g2l_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad;
    logic gmon_done;
    logic lyear_hit;
    logic lyear_end;
    logic lmon_hit;
  } g2l_sts_t;

  function automatic logic [16:0] year_word(input logic [7:0] i);
    logic [16:0] w;
    unique case (i)
      8'd0: w = 17'h04BD8; 8'd1: w = 17'h04AE0; 8'd2: w = 17'h0A570; 8'd3: w = 17'h054D5;
      8'd4: w = 17'h0D260; 8'd5: w = 17'h0D950; 8'd6: w = 17'h16554; 8'd7: w = 17'h056A0;
      8'd8: w = 17'h09AD0; 8'd9: w = 17'h055D2; 8'd10: w = 17'h04AE0; 8'd11: w = 17'h0A5B6;
      8'd12: w = 17'h0A4D0; 8'd13: w = 17'h0D250; 8'd14: w = 17'h1D255; 8'd15: w = 17'h0B540;
      8'd16: w = 17'h0D6A0; 8'd17: w = 17'h0ADA2; 8'd18: w = 17'h095B0; 8'd19: w = 17'h14977;
      8'd20: w = 17'h04970; 8'd21: w = 17'h0A4B0; 8'd22: w = 17'h0B4B5; 8'd23: w = 17'h06A50;
      8'd24: w = 17'h06D40; 8'd25: w = 17'h1AB54; 8'd26: w = 17'h02B60; 8'd27: w = 17'h09570;
      8'd28: w = 17'h052F2; 8'd29: w = 17'h04970; 8'd30: w = 17'h06566; 8'd31: w = 17'h0D4A0;
      8'd32: w = 17'h0EA50; 8'd33: w = 17'h06E95; 8'd34: w = 17'h05AD0; 8'd35: w = 17'h02B60;
      8'd36: w = 17'h186E3; 8'd37: w = 17'h092E0; 8'd38: w = 17'h1C8D7; 8'd39: w = 17'h0C950;
      8'd40: w = 17'h0D4A0; 8'd41: w = 17'h1D8A6; 8'd42: w = 17'h0B550; 8'd43: w = 17'h056A0;
      8'd44: w = 17'h1A5B4; 8'd45: w = 17'h025D0; 8'd46: w = 17'h092D0; 8'd47: w = 17'h0D2B2;
      8'd48: w = 17'h0A950; 8'd49: w = 17'h0B557; 8'd50: w = 17'h06CA0; 8'd51: w = 17'h0B550;
      8'd52: w = 17'h15355; 8'd53: w = 17'h04DA0; 8'd54: w = 17'h0A5B0; 8'd55: w = 17'h14573;
      8'd56: w = 17'h052B0; 8'd57: w = 17'h0A9A8; 8'd58: w = 17'h0E950; 8'd59: w = 17'h06AA0;
      8'd60: w = 17'h0AEA6; 8'd61: w = 17'h0AB50; 8'd62: w = 17'h04B60; 8'd63: w = 17'h0AAE4;
      8'd64: w = 17'h0A570; 8'd65: w = 17'h05260; 8'd66: w = 17'h0F263; 8'd67: w = 17'h0D950;
      8'd68: w = 17'h05B57; 8'd69: w = 17'h056A0; 8'd70: w = 17'h096D0; 8'd71: w = 17'h04DD5;
      8'd72: w = 17'h04AD0; 8'd73: w = 17'h0A4D0; 8'd74: w = 17'h0D4D4; 8'd75: w = 17'h0D250;
      8'd76: w = 17'h0D558; 8'd77: w = 17'h0B540; 8'd78: w = 17'h0B6A0; 8'd79: w = 17'h195A6;
      8'd80: w = 17'h095B0; 8'd81: w = 17'h049B0; 8'd82: w = 17'h0A974; 8'd83: w = 17'h0A4B0;
      8'd84: w = 17'h0B27A; 8'd85: w = 17'h06A50; 8'd86: w = 17'h06D40; 8'd87: w = 17'h0AF46;
      8'd88: w = 17'h0AB60; 8'd89: w = 17'h09570; 8'd90: w = 17'h04AF5; 8'd91: w = 17'h04970;
      8'd92: w = 17'h064B0; 8'd93: w = 17'h074A3; 8'd94: w = 17'h0EA50; 8'd95: w = 17'h06B58;
      8'd96: w = 17'h055C0; 8'd97: w = 17'h0AB60; 8'd98: w = 17'h096D5; 8'd99: w = 17'h092E0;
      8'd100: w = 17'h0C960; 8'd101: w = 17'h0D954; 8'd102: w = 17'h0D4A0; 8'd103: w = 17'h0DA50;
      8'd104: w = 17'h07552; 8'd105: w = 17'h056A0; 8'd106: w = 17'h0ABB7; 8'd107: w = 17'h025D0;
      8'd108: w = 17'h092D0; 8'd109: w = 17'h0CAB5; 8'd110: w = 17'h0A950; 8'd111: w = 17'h0B4A0;
      8'd112: w = 17'h0BAA4; 8'd113: w = 17'h0AD50; 8'd114: w = 17'h055D9; 8'd115: w = 17'h04BA0;
      8'd116: w = 17'h0A5B0; 8'd117: w = 17'h15176; 8'd118: w = 17'h052B0; 8'd119: w = 17'h0A930;
      8'd120: w = 17'h07954; 8'd121: w = 17'h06AA0; 8'd122: w = 17'h0AD50; 8'd123: w = 17'h05B52;
      8'd124: w = 17'h04B60; 8'd125: w = 17'h0A6E6; 8'd126: w = 17'h0A4E0; 8'd127: w = 17'h0D260;
      8'd128: w = 17'h0EA65; 8'd129: w = 17'h0D530; 8'd130: w = 17'h05AA0; 8'd131: w = 17'h076A3;
      8'd132: w = 17'h096D0; 8'd133: w = 17'h04BD7; 8'd134: w = 17'h04AD0; 8'd135: w = 17'h0A4D0;
      8'd136: w = 17'h1D0B6; 8'd137: w = 17'h0D250; 8'd138: w = 17'h0D520; 8'd139: w = 17'h0DD45;
      8'd140: w = 17'h0B5A0; 8'd141: w = 17'h056D0; 8'd142: w = 17'h055B2; 8'd143: w = 17'h049B0;
      8'd144: w = 17'h0A577; 8'd145: w = 17'h0A4B0; 8'd146: w = 17'h0AA50; 8'd147: w = 17'h1B255;
      8'd148: w = 17'h06D20; 8'd149: w = 17'h0ADA0; 8'd150: w = 17'h14B63; 8'd151: w = 17'h09370;
      8'd152: w = 17'h049F8; 8'd153: w = 17'h04970; 8'd154: w = 17'h064B0; 8'd155: w = 17'h168A6;
      8'd156: w = 17'h0EA50; 8'd157: w = 17'h06B20; 8'd158: w = 17'h1A6C4; 8'd159: w = 17'h0AAE0;
      8'd160: w = 17'h092E0; 8'd161: w = 17'h0D2E3; 8'd162: w = 17'h0C960; 8'd163: w = 17'h0D557;
      8'd164: w = 17'h0D4A0; 8'd165: w = 17'h0DA50; 8'd166: w = 17'h05D55; 8'd167: w = 17'h056A0;
      8'd168: w = 17'h0A6D0; 8'd169: w = 17'h055D4; 8'd170: w = 17'h052D0; 8'd171: w = 17'h0A9B8;
      8'd172: w = 17'h0A950; 8'd173: w = 17'h0B4A0; 8'd174: w = 17'h0B6A6; 8'd175: w = 17'h0AD50;
      8'd176: w = 17'h055A0; 8'd177: w = 17'h0ABA4; 8'd178: w = 17'h0A5B0; 8'd179: w = 17'h052B0;
      8'd180: w = 17'h0B273; 8'd181: w = 17'h06930; 8'd182: w = 17'h07337; 8'd183: w = 17'h06AA0;
      8'd184: w = 17'h0AD50; 8'd185: w = 17'h14B55; 8'd186: w = 17'h04B60; 8'd187: w = 17'h0A570;
      8'd188: w = 17'h054E4; 8'd189: w = 17'h0D260; 8'd190: w = 17'h0E968; 8'd191: w = 17'h0D520;
      8'd192: w = 17'h0DAA0; 8'd193: w = 17'h16AA6; 8'd194: w = 17'h056D0; 8'd195: w = 17'h04AE0;
      8'd196: w = 17'h0A9D4; 8'd197: w = 17'h0A4D0; 8'd198: w = 17'h0D150; 8'd199: w = 17'h0F252;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== design/g2l_ctrl.sv =====
`default_nettype none
`include "gregorian_to_lunar_date_assert.svh"
module g2l_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire g2l_pkg::g2l_sts_t sts,
  output g2l_pkg::g2l_cmd_t    cmd
);
  import g2l_pkg::*;

  g2l_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.bad ? ST_DONE : ST_GMON;
      ST_GMON:  if (sts.gmon_done) state_nxt = ST_LYEAR;
      ST_LYEAR: begin
        if (sts.lyear_end) state_nxt = ST_DONE;
        else if (sts.lyear_hit) state_nxt = ST_LMON;
      end
      ST_LMON:  if (sts.lmon_hit) state_nxt = ST_DONE;
      ST_DONE:  if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    unique case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_CHECK: begin
        cmd.check = 1'b1;
        cmd.fail = sts.bad;
      end
      ST_GMON:  cmd.gmon_step = 1'b1;
      ST_LYEAR: begin
        cmd.lyear_step = 1'b1;
        cmd.fail = sts.lyear_end;
      end
      ST_LMON:  cmd.lmon_step = 1'b1;
      default:  ;
    endcase
  end

  `G2L_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "result beat dropped while stalled")
  `G2L_ASSERT_IMP(a_one_phase, clk, rst_n, 1'b1, $onehot0({out_valid, !in_stall}),
    "accepting while a result is pending")
  `G2L_ASSERT_NXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_r == ST_CHECK,
    "accepted beat did not start work")
endmodule
`default_nettype wire

// ===== design/g2l_dp.sv =====
`default_nettype none
module g2l_dp #(
  parameter int unsigned TABLE_YEARS = g2l_pkg::TableYearsDef
) (
  input  wire logic              clk,
  input  wire g2l_pkg::g2l_in_t  in_data,
  input  wire g2l_pkg::g2l_cmd_t cmd,
  output g2l_pkg::g2l_sts_t      sts,
  output g2l_pkg::g2l_out_t      out_data
);
  import g2l_pkg::*;

  localparam int unsigned Span = (TABLE_YEARS < RomWords) ? TABLE_YEARS : RomWords;

  logic [11:0] y_r;
  logic [3:0]  mo_r, gm_r;
  logic [4:0]  d_r;
  logic [16:0] off_r, off_nxt;
  logic [7:0]  idx_r;
  logic [3:0]  lm_r;
  logic        in_leap_r;
  g2l_out_t    res_r;

  logic [16:0] w;
  logic        gleap;
  logic [4:0]  glen_mo, glen_gm;
  logic [8:0]  ylen;
  logic [3:0]  lp;
  logic [4:0]  mlen, llen;
  logic [4:0]  cur_len;
  logic [11:0] dy;
  logic [16:0] base_off;
  logic [6:0]  nl;

  function automatic logic [4:0] glen(input logic [3:0] m, input logic lpy);
    logic [4:0] r;
    unique case (m)
      4'd2: r = lpy ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  always_comb begin
    // Year is within 1900..2099 when checked, so the 100/400 rule reduces to 1900 and 2100.
    gleap = (y_r[1:0] == 2'b00) && (y_r != 12'd1900) && (y_r != 12'd2100);
    glen_mo = glen(mo_r, gleap);
    glen_gm = glen(gm_r, gleap);
    dy = y_r - 12'(BaseYear);
    // Leap days in 1900..y-1: years 1904..; 2000 is a leap year.
    nl = 7'((dy + 12'd3) >> 2) - 7'd1;
    if (dy == 12'd0) nl = 7'd0;
    base_off = 17'(dy) * 17'd365 + 17'(nl) + 17'(d_r) - 17'd31;
    w = year_word(idx_r);
    lp = (w[3:0] <= 4'd12) ? w[3:0] : 4'd0;
    llen = (lp == 4'd0) ? 5'd0 : (w[16] ? 5'd30 : 5'd29);
    ylen = 9'd348 + 9'($countones(w[15:4])) + 9'(llen);
    mlen = w[5'd16 - 5'(lm_r)] ? 5'd30 : 5'd29;
    cur_len = in_leap_r ? llen : mlen;
  end

  always_comb begin
    sts.bad = (y_r < 12'(BaseYear)) || (32'(y_r) - BaseYear >= Span)
           || (mo_r == 4'd0) || (mo_r > 4'd12) || (d_r == 5'd0) || (d_r > glen_mo)
           || ((y_r == 12'(BaseYear)) && (mo_r == 4'd1) && (d_r < 5'd31));
    sts.gmon_done = (gm_r >= mo_r);
    sts.lyear_hit = (off_r < 17'(ylen));
    sts.lyear_end = !sts.lyear_hit && (32'(idx_r) + 1 >= Span);
    sts.lmon_hit = (off_r < 17'(cur_len));
  end

  always_comb begin
    off_nxt = off_r;
    if (cmd.check) off_nxt = base_off;
    else if (cmd.gmon_step && !sts.gmon_done) off_nxt = off_r + 17'(glen_gm);
    else if (cmd.lyear_step && !sts.lyear_hit) off_nxt = off_r - 17'(ylen);
    else if (cmd.lmon_step && !sts.lmon_hit) off_nxt = off_r - 17'(cur_len);
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    if (cmd.load) begin
      y_r <= in_data.greg_year;
      mo_r <= in_data.greg_month;
      d_r <= in_data.greg_day;
      gm_r <= 4'd1;
      idx_r <= '0;
      lm_r <= 4'd1;
      in_leap_r <= 1'b0;
    end
    if (cmd.gmon_step && !sts.gmon_done) gm_r <= gm_r + 4'd1;
    if (cmd.lyear_step && !sts.lyear_hit && !sts.lyear_end) idx_r <= idx_r + 8'd1;
    if (cmd.lmon_step && !sts.lmon_hit) begin
      // Advance: a leap month follows its base month.
      if (!in_leap_r && (lp == lm_r)) in_leap_r <= 1'b1;
      else begin
        in_leap_r <= 1'b0;
        lm_r <= lm_r + 4'd1;
      end
    end
    if (cmd.fail) res_r <= '0;
    else if (cmd.lmon_step && sts.lmon_hit) begin
      res_r.valid_res <= 1'b1;
      res_r.lunar_year <= 12'(BaseYear) + 12'(idx_r);
      res_r.lunar_month <= lm_r;
      res_r.lunar_day <= 5'(off_r) + 5'd1;
      res_r.leap_month_flag <= in_leap_r;
    end
  end

  assign out_data = res_r;
endmodule
`default_nettype wire

// ===== design/gregorian_to_lunar_date.sv =====
// Steps: the range check, the Gregorian month walk, the lunar year walk, the lunar month walk, then the result.
// A date rejected by the range and calendar checks goes from the check straight to the result.
// Throughput: one item at a time; the next beat is taken after the result beat leaves.
// The run length is set by the one-per-cycle year and month walk over the year ROM.
// Reset: synchronous active-low rst_n returns the controller to idle with no result pending.
`default_nettype none
module gregorian_to_lunar_date #(
  parameter int unsigned TABLE_YEARS = g2l_pkg::TableYearsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire g2l_pkg::g2l_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output g2l_pkg::g2l_out_t      out_data
);
  import g2l_pkg::*;

  g2l_cmd_t cmd;
  g2l_sts_t sts;

  g2l_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  g2l_dp #(.TABLE_YEARS(TABLE_YEARS)) u_dp (
    .clk, .in_data, .cmd, .sts, .out_data
  );
endmodule
`default_nettype wire
